// ===== design/reoed_pkg.sv =====
// Shared types, constants and the phase transition table for the rotary encoder decoder.
`timescale 1ns / 1ps

package reoed_pkg;

    // Field widths fixed by the interface
    localparam int TIME_IN_BITS   = 32;
    localparam int HOLDOFF_BITS   = 20;
    localparam int CFG_INDEX_BITS = 2;
    localparam int SUM_BITS       = 4;
    localparam int COUNT_BITS     = 3;

    // Quarter steps that make up one detent
    localparam logic [COUNT_BITS-1:0] STEPS_PER_DETENT = 3'd4;

    // Reset values of the hold-off registers
    localparam logic [HOLDOFF_BITS-1:0] ROTATE_HOLDOFF_RESET = 20'd5000;
    localparam logic [HOLDOFF_BITS-1:0] BUTTON_HOLDOFF_RESET = 20'd50000;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROTATE_HOLDOFF = 2'd0,
        CFG_BUTTON_HOLDOFF = 2'd1
    } cfg_index_t;

    // Input event kinds
    typedef enum logic {
        MODE_ROTATE = 1'b0,
        MODE_BUTTON = 1'b1
    } mode_t;

    // Result event codes
    typedef enum logic [1:0] {
        EV_CW    = 2'd0,
        EV_CCW   = 2'd1,
        EV_CLICK = 2'd2
    } event_code_t;

    // Score of an old/new phase pair, indexed by {prev_phase, cur_phase}
    localparam logic signed [1:0] PHASE_SCORE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    // One pin event as it sits in the input register
    typedef struct packed {
        logic                    mode;
        logic [TIME_IN_BITS-1:0] time_us;
        logic                    phase_a;
        logic                    phase_b;
        logic                    button_level;
    } pin_item_t;

    // Hold-off settings handed from the register file to the decoder
    typedef struct packed {
        logic [HOLDOFF_BITS-1:0] rotate_holdoff_us;
        logic [HOLDOFF_BITS-1:0] button_holdoff_us;
    } holdoff_cfg_t;

    // Decoder outcome for one item
    typedef struct packed {
        logic        emit;
        event_code_t code;
    } step_result_t;

endpackage

// ===== design/reoed_if.sv =====
// Handshake interfaces for pin events, decoded events and configuration writes.
`timescale 1ns / 1ps

interface reoed_pin_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] time_us;
    logic        phase_a;
    logic        phase_b;
    logic        button_level;

    modport source (output valid, mode, time_us, phase_a, phase_b, button_level, input ready);
    modport sink   (input valid, mode, time_us, phase_a, phase_b, button_level, output ready);
endinterface

interface reoed_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;

    modport source (output valid, event_code, input ready);
    modport sink   (input valid, event_code, output ready);
endinterface

interface reoed_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/reoed_cfg.sv =====
// Hold-off configuration registers.
`timescale 1ns / 1ps

module reoed_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    reoed_cfg_if.sink             cfg,
    output reoed_pkg::holdoff_cfg_t holdoff
);

    logic [reoed_pkg::HOLDOFF_BITS-1:0] rotate_holdoff_reg;
    logic [reoed_pkg::HOLDOFF_BITS-1:0] rotate_holdoff_next;
    logic [reoed_pkg::HOLDOFF_BITS-1:0] button_holdoff_reg;
    logic [reoed_pkg::HOLDOFF_BITS-1:0] button_holdoff_next;

    // Accept every write request at once
    assign cfg.ready = 1'b1;

    // Decode the register index; drop writes to unknown indexes
    always_comb
    begin
        rotate_holdoff_next = rotate_holdoff_reg;
        button_holdoff_next = button_holdoff_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                reoed_pkg::CFG_ROTATE_HOLDOFF: rotate_holdoff_next = cfg.data;
                reoed_pkg::CFG_BUTTON_HOLDOFF: button_holdoff_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotate_holdoff_reg <= reoed_pkg::ROTATE_HOLDOFF_RESET;
            button_holdoff_reg <= reoed_pkg::BUTTON_HOLDOFF_RESET;
        end
        else
        begin
            rotate_holdoff_reg <= rotate_holdoff_next;
            button_holdoff_reg <= button_holdoff_next;
        end
    end

    assign holdoff.rotate_holdoff_us = rotate_holdoff_reg;
    assign holdoff.button_holdoff_us = button_holdoff_reg;

endmodule

// ===== design/reoed_step.sv =====
// Decoder state and the single-pass update for one pin event.
`timescale 1ns / 1ps

module reoed_step #(
    parameter int TIME_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  reoed_pkg::pin_item_t    item,
    input  reoed_pkg::holdoff_cfg_t holdoff,
    output reoed_pkg::step_result_t result
);

    // Width wide enough for both a time difference and a hold-off value
    localparam int CMP_BITS =
        (TIME_BITS > reoed_pkg::HOLDOFF_BITS) ? TIME_BITS : reoed_pkg::HOLDOFF_BITS;

    logic [1:0]                         prev_phase_reg;
    logic [1:0]                         prev_phase_next;
    logic signed [reoed_pkg::SUM_BITS-1:0] step_sum_reg;
    logic signed [reoed_pkg::SUM_BITS-1:0] step_sum_next;
    logic [reoed_pkg::COUNT_BITS-1:0]   count_reg;
    logic [reoed_pkg::COUNT_BITS-1:0]   count_next;
    logic [TIME_BITS-1:0]               last_rotate_reg;
    logic [TIME_BITS-1:0]               last_rotate_next;
    logic [TIME_BITS-1:0]               last_button_reg;
    logic [TIME_BITS-1:0]               last_button_next;

    logic [TIME_BITS+reoed_pkg::TIME_IN_BITS-1:0] time_ext;
    logic [TIME_BITS-1:0]               now;
    logic [TIME_BITS-1:0]               rotate_diff;
    logic [TIME_BITS-1:0]               button_diff;
    logic                               rotate_hold;
    logic                               button_hold;
    logic [1:0]                         cur_phase;
    logic signed [1:0]                  score;
    logic signed [reoed_pkg::SUM_BITS-1:0] sum_add;
    logic [reoed_pkg::COUNT_BITS-1:0]   count_add;

    // Fit the timestamp to the time width
    assign time_ext = {{TIME_BITS{1'b0}}, item.time_us};
    assign now      = time_ext[TIME_BITS-1:0];

    // Hold-off windows, differences wrap at the time width
    assign rotate_diff = now - last_rotate_reg;
    assign button_diff = now - last_button_reg;
    assign rotate_hold = CMP_BITS'(rotate_diff) < CMP_BITS'(holdoff.rotate_holdoff_us);
    assign button_hold = CMP_BITS'(button_diff) < CMP_BITS'(holdoff.button_holdoff_us);

    // Score the phase change
    assign cur_phase = {item.phase_a, item.phase_b};
    assign score     = reoed_pkg::PHASE_SCORE[{prev_phase_reg, cur_phase}];
    assign sum_add   = step_sum_reg + reoed_pkg::SUM_BITS'(score);
    assign count_add = count_reg + 1'b1;

    // Work out the next state and the result of this item
    always_comb
    begin
        prev_phase_next  = prev_phase_reg;
        step_sum_next    = step_sum_reg;
        count_next       = count_reg;
        last_rotate_next = last_rotate_reg;
        last_button_next = last_button_reg;
        result.emit      = 1'b0;
        result.code      = reoed_pkg::EV_CW;

        unique case (reoed_pkg::mode_t'(item.mode))
            reoed_pkg::MODE_ROTATE:
            begin
                if (!rotate_hold)
                begin
                    prev_phase_next = cur_phase;
                    if (score != 2'sd0 && cur_phase != prev_phase_reg)
                    begin
                        if (count_add >= reoed_pkg::STEPS_PER_DETENT)
                        begin
                            result.emit      = 1'b1;
                            result.code      = sum_add[reoed_pkg::SUM_BITS-1]
                                             ? reoed_pkg::EV_CCW : reoed_pkg::EV_CW;
                            step_sum_next    = '0;
                            count_next       = '0;
                            last_rotate_next = now;
                        end
                        else
                        begin
                            step_sum_next = sum_add;
                            count_next    = count_add;
                        end
                    end
                end
            end
            reoed_pkg::MODE_BUTTON:
            begin
                if (!button_hold)
                begin
                    last_button_next = now;
                    if (!item.button_level)
                    begin
                        result.emit = 1'b1;
                        result.code = reoed_pkg::EV_CLICK;
                    end
                end
            end
            default: ;
        endcase
    end

    // Commit the state when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_phase_reg  <= '0;
            step_sum_reg    <= '0;
            count_reg       <= '0;
            last_rotate_reg <= '0;
            last_button_reg <= '0;
        end
        else if (advance)
        begin
            prev_phase_reg  <= prev_phase_next;
            step_sum_reg    <= step_sum_next;
            count_reg       <= count_next;
            last_rotate_reg <= last_rotate_next;
            last_button_reg <= last_button_next;
        end
    end

endmodule

// ===== design/rotary_encoder_event_decoder_top.sv =====
// Top level of the rotary encoder event decoder: input register, decoder and result register.
`timescale 1ns / 1ps

// Decodes time-stamped pin events from a quadrature knob with push button into
// clockwise, counter-clockwise and click events. Each request is captured in an
// input register and, once the result register can take it, resolved by one pass
// through the decoder logic into the result register, so one request is accepted
// every cycle unless the result register stalls; the result register is the
// only point of back-pressure, and a new request is still taken while a finished
// event waits there as long as the decoded item can move into it. Hold-offs are
// in timestamp units and differences wrap at TIME_BITS. Configuration writes are
// taken at any time but must only be issued while no request is in flight.
module rotary_encoder_event_decoder_top #(
    parameter int TIME_BITS = 32
) (
    input logic         clk,
    input logic         rst_n,
    reoed_pin_if.sink   pin_evt,
    reoed_cfg_if.sink   cfg,
    reoed_evt_if.source ui_evt
);

    reoed_pkg::holdoff_cfg_t holdoff;
    reoed_pkg::step_result_t result;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    reoed_pkg::pin_item_t item_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           out_code_reg;
    logic                 out_free;
    logic                 advance;
    logic                 take;

    // Configuration registers
    reoed_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .holdoff (holdoff)
    );

    // Decoder state and update
    reoed_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .holdoff (holdoff),
        .result  (result)
    );

    // Move the held item into the decoder when the result slot can take it
    assign out_free      = !out_valid_reg || ui_evt.ready;
    assign advance       = in_valid_reg && out_free;
    assign pin_evt.ready = !in_valid_reg || advance;
    assign take          = pin_evt.valid && pin_evt.ready;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = (advance && result.emit) || (out_valid_reg && !ui_evt.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.mode         <= pin_evt.mode;
            item_reg.time_us      <= pin_evt.time_us;
            item_reg.phase_a      <= pin_evt.phase_a;
            item_reg.phase_b      <= pin_evt.phase_b;
            item_reg.button_level <= pin_evt.button_level;
        end
    end

    // Hold the event code until it is taken
    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            out_code_reg <= result.code;
        end
    end

    assign ui_evt.valid      = out_valid_reg;
    assign ui_evt.event_code = out_code_reg;

endmodule

// ===== sim/rotary_encoder_event_decoder_top_tb.sv =====
// Self-checking testbench for the rotary encoder event decoder top level.
`timescale 1ns / 1ps

module rotary_encoder_event_decoder_top_tb;
    import reoed_pkg::*;

    localparam int                          CLK_HALF_NS = 5;
    localparam int                          RESET_CYCLES = 7;
    localparam int                          RANDOM_PHASES = 6;
    localparam int                          ITEMS_PER_PHASE = 190;
    localparam int                          SETTLE_CYCLES = 8;
    localparam int                          DRAIN_LIMIT = 4000;
    localparam int                          QUARTERS_PER_DETENT = 4;
    localparam logic [HOLDOFF_BITS-1:0]     HOLDOFF_MAX = 20'd1000000;
    // Register indexes with no register behind them
    localparam logic [CFG_INDEX_BITS-1:0]   CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0]   CFG_SPARE_B = 2'd3;

    // Quarter-step score indexed by {old phase, new phase}
    localparam int QUAD_STEP [16] = '{
         0, -1,  1,  0,
         1,  0,  0, -1,
        -1,  0,  0,  1,
         0,  1, -1,  0
    };

    logic clk;
    logic rst_n;

    reoed_pin_if pin ();
    reoed_cfg_if cfg ();
    reoed_evt_if evt ();

    rotary_encoder_event_decoder_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pin_evt (pin),
        .cfg     (cfg),
        .ui_evt  (evt)
    );

    // Decoder state mirrored by the predictor
    logic [HOLDOFF_BITS-1:0] rotate_holdoff;
    logic [HOLDOFF_BITS-1:0] button_holdoff;
    logic [1:0]              knob_phase;
    int                      step_total;
    int                      quarter_count;
    logic [31:0]             last_rotate_us;
    logic [31:0]             last_button_us;

    pin_item_t   pending_pins [$];
    event_code_t expected_events [$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int accepted_pins;
    int cw_seen;
    int ccw_seen;
    int click_seen;
    int cfg_writes;

    // Stimulus generator state
    logic [31:0] gen_time;
    logic [1:0]  gen_phase;
    logic        gen_cw;

    // Advance the clock
    initial clk = 1'b0;
    always #CLK_HALF_NS clk = ~clk;

    // Score one accepted pin event and queue the decoded event it causes
    function automatic void decode_pin_event(input pin_item_t item);
        logic [31:0] gap;
        logic [1:0]  now_phase;
        int          score;
        if (item.mode == MODE_ROTATE) begin
            gap = item.time_us - last_rotate_us;
            if (gap < {12'd0, rotate_holdoff})
                return;
            now_phase = {item.phase_a, item.phase_b};
            score = QUAD_STEP[{knob_phase, now_phase}];
            if (score != 0 && now_phase != knob_phase) begin
                step_total += score;
                quarter_count++;
                if (quarter_count >= QUARTERS_PER_DETENT) begin
                    expected_events.push_back(step_total < 0 ? EV_CCW : EV_CW);
                    step_total = 0;
                    quarter_count = 0;
                    last_rotate_us = item.time_us;
                end
            end
            knob_phase = now_phase;
        end
        else begin
            gap = item.time_us - last_button_us;
            if (gap < {12'd0, button_holdoff})
                return;
            last_button_us = item.time_us;
            if (item.button_level == 1'b0)
                expected_events.push_back(EV_CLICK);
        end
    endfunction

    // Next phase of a clean quadrature walk
    function automatic logic [1:0] walk_phase(input logic [1:0] p, input logic cw);
        case (p)
            2'd0:    walk_phase = cw ? 2'd2 : 2'd1;
            2'd2:    walk_phase = cw ? 2'd3 : 2'd0;
            2'd3:    walk_phase = cw ? 2'd1 : 2'd2;
            default: walk_phase = cw ? 2'd0 : 2'd3;
        endcase
    endfunction

    task automatic push_pin(input mode_t m, input logic [31:0] t, input logic [1:0] ph,
                            input logic btn);
        pin_item_t item;
        item.mode         = m;
        item.time_us      = t;
        item.phase_a      = ph[1];
        item.phase_b      = ph[0];
        item.button_level = btn;
        pending_pins.push_back(item);
    endtask

    // Hold until every request is taken and every event is back or the wait limit runs out, then settle
    task automatic drain();
        int waited;
        waited = 0;
        while (pending_pins.size() > 0 || pin.valid ||
               (expected_events.size() > 0 && waited < DRAIN_LIMIT)) begin
            @(negedge clk);
            if (pending_pins.size() == 0 && !pin.valid)
                waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write; the model takes it on the handshake
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [HOLDOFF_BITS-1:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_ROTATE_HOLDOFF)
            rotate_holdoff = value;
        else if (idx == CFG_BUTTON_HOLDOFF)
            button_holdoff = value;
        cfg_writes++;
        @(negedge clk);
    endtask

    // Build one random request, mostly clean quadrature walks
    task automatic gen_random_pin();
        int          pick;
        logic [31:0] span;
        logic [1:0]  ph;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 6) begin
            gen_time = $urandom;
            span = 0;
        end
        else if (pick < 72)
            span = ($urandom_range(0, 99) < 60) ? (rotate_holdoff / 8 + 3)
                                                : (rotate_holdoff * 2 + 16);
        else
            span = button_holdoff * 2 + 16;
        gen_time = gen_time + $urandom_range(0, span);

        if (pick < 62) begin
            if ($urandom_range(0, 99) < 12)
                gen_cw = ~gen_cw;
            gen_phase = walk_phase(gen_phase, ($urandom_range(0, 99) < 10) ? ~gen_cw : gen_cw);
            push_pin(MODE_ROTATE, gen_time, gen_phase, $urandom_range(0, 1));
        end
        else if (pick < 72) begin
            ph = $urandom_range(0, 3);
            gen_phase = ph;
            push_pin(MODE_ROTATE, gen_time, ph, $urandom_range(0, 1));
        end
        else begin
            push_pin(MODE_BUTTON, gen_time, $urandom_range(0, 3),
                     $urandom_range(0, 99) >= 40);
        end
    endtask

    // Drive pin requests from the pending queue; hold an offered request until taken
    always @(posedge clk or negedge rst_n) begin
        pin_item_t item;
        if (!rst_n) begin
            pin.valid <= 1'b0;
        end
        else begin
            if (pin.valid && pin.ready) begin
                item = pending_pins.pop_front();
                decode_pin_event(item);
                accepted_pins++;
            end
            if (pin.valid && !pin.ready) begin
                // keep the current request on the bus
            end
            else if (pending_pins.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item = pending_pins[0];
                pin.valid        <= 1'b1;
                pin.mode         <= item.mode;
                pin.time_us      <= item.time_us;
                pin.phase_a      <= item.phase_a;
                pin.phase_b      <= item.phase_b;
                pin.button_level <= item.button_level;
            end
            else begin
                pin.valid <= 1'b0;
            end
        end
    end

    // Check decoded events against the oldest prediction; stall at random
    always @(posedge clk or negedge rst_n) begin
        event_code_t want;
        if (!rst_n) begin
            evt.ready <= 1'b0;
        end
        else begin
            if (evt.valid && evt.ready) begin
                if (expected_events.size() == 0) begin
                    $error("event_code: expected none, got %0d", evt.event_code);
                    fail_count++;
                end
                else begin
                    want = expected_events.pop_front();
                    if (evt.event_code !== want) begin
                        $error("event_code: expected %0d, got %0d", want, evt.event_code);
                        fail_count++;
                    end
                    case (want)
                        EV_CW:   cw_seen++;
                        EV_CCW:  ccw_seen++;
                        default: click_seen++;
                    endcase
                end
            end
            evt.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("rotary_encoder_event_decoder_top_tb: FAIL");
        $finish;
    end

    initial begin
        rst_n            = 1'b0;
        pin.valid        = 1'b0;
        pin.mode         = MODE_ROTATE;
        pin.time_us      = '0;
        pin.phase_a      = 1'b0;
        pin.phase_b      = 1'b0;
        pin.button_level = 1'b1;
        cfg.valid        = 1'b0;
        cfg.index        = CFG_ROTATE_HOLDOFF;
        cfg.data         = '0;
        evt.ready        = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        fail_count       = 0;
        accepted_pins    = 0;
        cw_seen          = 0;
        ccw_seen         = 0;
        click_seen       = 0;
        cfg_writes       = 0;
        rotate_holdoff   = ROTATE_HOLDOFF_RESET;
        button_holdoff   = BUTTON_HOLDOFF_RESET;
        knob_phase       = 2'd0;
        step_total       = 0;
        quarter_count    = 0;
        last_rotate_us   = '0;
        last_button_us   = '0;
        gen_time         = '0;
        gen_phase        = 2'd0;
        gen_cw           = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset hold-offs still cover early timestamps
        push_pin(MODE_ROTATE, 32'd100,   2'd2, 1'b1);
        push_pin(MODE_BUTTON, 32'd49999, 2'd0, 1'b0);
        push_pin(MODE_BUTTON, 32'd50000, 2'd0, 1'b0);
        // Release restarts the window without an event
        push_pin(MODE_BUTTON, 32'd100000, 2'd0, 1'b1);
        push_pin(MODE_BUTTON, 32'd149999, 2'd0, 1'b0);
        push_pin(MODE_BUTTON, 32'd150000, 2'd0, 1'b0);
        // Clean clockwise detent
        push_pin(MODE_ROTATE, 32'd5000, 2'd2, 1'b1);
        push_pin(MODE_ROTATE, 32'd5001, 2'd3, 1'b1);
        push_pin(MODE_ROTATE, 32'd5002, 2'd1, 1'b1);
        push_pin(MODE_ROTATE, 32'd5003, 2'd0, 1'b1);
        // Edge inside the rotate hold-off, then unchanged phase, then a double step
        push_pin(MODE_ROTATE, 32'd5004,  2'd2, 1'b1);
        push_pin(MODE_ROTATE, 32'd10003, 2'd0, 1'b1);
        push_pin(MODE_ROTATE, 32'd10004, 2'd3, 1'b1);
        // Clean counter-clockwise detent
        push_pin(MODE_ROTATE, 32'd10005, 2'd2, 1'b0);
        push_pin(MODE_ROTATE, 32'd10006, 2'd0, 1'b0);
        push_pin(MODE_ROTATE, 32'd10007, 2'd1, 1'b0);
        push_pin(MODE_ROTATE, 32'd10008, 2'd3, 1'b0);
        // Back-and-forth with zero sum resolves clockwise
        push_pin(MODE_ROTATE, 32'd20000, 2'd1, 1'b1);
        push_pin(MODE_ROTATE, 32'd20001, 2'd3, 1'b1);
        push_pin(MODE_ROTATE, 32'd20002, 2'd1, 1'b1);
        push_pin(MODE_ROTATE, 32'd20003, 2'd3, 1'b1);
        // Timestamp wrap on the button window
        push_pin(MODE_BUTTON, 32'hFFFF_FFFF, 2'd3, 1'b0);
        push_pin(MODE_BUTTON, 32'd49998,     2'd3, 1'b0);
        push_pin(MODE_BUTTON, 32'd49999,     2'd3, 1'b0);
        push_pin(MODE_ROTATE, 32'hFFFF_FFFF, 2'd1, 1'b0);
        drain();
        gen_phase = knob_phase;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_ROTATE_HOLDOFF, '0);
                    write_reg(CFG_BUTTON_HOLDOFF, '0);
                end
                1: begin
                    write_reg(CFG_ROTATE_HOLDOFF, HOLDOFF_MAX);
                    write_reg(CFG_BUTTON_HOLDOFF, HOLDOFF_MAX);
                end
                2: begin
                    write_reg(CFG_ROTATE_HOLDOFF, ROTATE_HOLDOFF_RESET);
                    write_reg(CFG_BUTTON_HOLDOFF, BUTTON_HOLDOFF_RESET);
                end
                3: begin
                    write_reg(CFG_ROTATE_HOLDOFF, $urandom_range(1, 20000));
                    write_reg(CFG_BUTTON_HOLDOFF, $urandom_range(1, 100000));
                end
                4: begin
                    write_reg(CFG_ROTATE_HOLDOFF, 20'd20);
                    write_reg(CFG_BUTTON_HOLDOFF, 20'd1);
                    // Writes to unmapped indexes must leave both hold-offs alone
                    write_reg(CFG_SPARE_A, 20'hFFFFF);
                    write_reg(CFG_SPARE_B, 20'hFFFFF);
                end
                default: begin
                    write_reg(CFG_ROTATE_HOLDOFF, HOLDOFF_MAX);
                    write_reg(CFG_BUTTON_HOLDOFF, '0);
                end
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                gen_random_pin();
            drain();
        end

        if (expected_events.size() > 0) begin
            $error("event_code: %0d expected events never arrived", expected_events.size());
            fail_count++;
        end
        $display("Covered %0d pin requests over %0d register writes and %0d hold-off setups.",
                 accepted_pins, cfg_writes, RANDOM_PHASES + 1);
        $display("Decoded events checked: %0d clockwise, %0d counter-clockwise, %0d clicks.",
                 cw_seen, ccw_seen, click_seen);
        if (fail_count == 0)
            $display("rotary_encoder_event_decoder_top_tb: PASS");
        else
            $display("rotary_encoder_event_decoder_top_tb: FAIL");
        $finish;
    end

endmodule
